/* rtl/ascii_integer_parser_top_macros.svh */
// Assertion macros for the ASCII integer parser.
// Included by the top level; the macros expect clk and arst_n in scope.
`ifndef ASCII_INTEGER_PARSER_TOP_MACROS_SVH
`define ASCII_INTEGER_PARSER_TOP_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define AIP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("aip: same-cycle check failed");

// Next-cycle implication, quiet during reset.
`define AIP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("aip: next-cycle check failed");

`endif

/* rtl/aip_pkg.sv */
// Shared types, character codes and helpers for the ASCII integer parser.
// No dependencies.
package aip_pkg;

	// register indexes of the configuration port
	localparam logic CFG_NUMBER_BASE = 1'b0;
	localparam logic CFG_SIGNED_MODE = 1'b1;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF_HEX = 8'h66;
	localparam logic [7:0] CH_LX    = 8'h78;

	// digit value of a character that is no hex digit; above any 6-bit base
	localparam logic [6:0] NOT_DIGIT = 7'h40;

	localparam logic [5:0] BASE_OCT = 6'd8;
	localparam logic [5:0] BASE_DEC = 6'd10;
	localparam logic [5:0] BASE_HEX = 6'd16;
	localparam logic [7:0] COUNT_MAX = 8'hFF;

	typedef enum logic [5:0] {
		PH_START       = 6'b000001,
		PH_AFTER_MINUS = 6'b000010,
		PH_AFTER_ZERO  = 6'b000100,
		PH_AFTER_X     = 6'b001000,
		PH_DIGITS      = 6'b010000,
		PH_DONE        = 6'b100000
	} aip_phase_t;

	// per-line parse state, accumulator kept apart as its width varies
	typedef struct packed {
		aip_phase_t  phase;
		logic [5:0]  active_base;
		logic        negate;
		logic [7:0]  char_count;
		logic [7:0]  stop_pos;
	} aip_line_t;

	localparam aip_line_t LINE_RESET = '{
		phase:       PH_START,
		active_base: 6'd0,
		negate:      1'b0,
		char_count:  8'd0,
		stop_pos:    8'd0
	};

	function automatic logic [6:0] hex_value(input logic [7:0] c);
		logic [6:0] r;
		r = NOT_DIGIT;
		if (c >= CH_0 && c <= CH_9) begin
			r = 7'(c - CH_0);
		end else if (c >= CH_UA && c <= CH_UF) begin
			r = 7'(c - CH_UA + 8'd10);
		end else if (c >= CH_LA && c <= CH_LF_HEX) begin
			r = 7'(c - CH_LA + 8'd10);
		end
		return r;
	endfunction

	function automatic logic [7:0] sat_inc(input logic [7:0] x);
		return (x == COUNT_MAX) ? COUNT_MAX : x + 8'd1;
	endfunction

endpackage

/* rtl/aip_step.sv */
// Next-state and result logic for one character of the parser.
// Depends on aip_pkg.
module aip_step #(
	parameter int VALUE_WIDTH = 32
) (
	input  aip_pkg::aip_line_t     cur,
	input  logic [VALUE_WIDTH-1:0] acc,
	input  logic [7:0]             ch,
	input  logic [5:0]             number_base,
	input  logic                   signed_mode,
	output aip_pkg::aip_line_t     nxt,
	output logic [VALUE_WIDTH-1:0] acc_nxt,
	output logic                   is_end,
	output logic [VALUE_WIDTH-1:0] res_value,
	output logic [7:0]             res_stop
);

	logic [6:0]             dig;
	logic [7:0]             idx_inc;
	logic [5:0]             use_base;
	logic                   try_dig;
	logic                   begin_num;
	logic [VALUE_WIDTH+5:0] prod;

	assign is_end  = (ch == aip_pkg::CH_CR) || (ch == aip_pkg::CH_LF) ||
	                 (ch == aip_pkg::CH_NUL);
	assign dig     = aip_pkg::hex_value(ch);
	assign idx_inc = aip_pkg::sat_inc(cur.char_count);

	assign res_value = cur.negate ? (VALUE_WIDTH'(0) - acc) : acc;
	assign res_stop  = cur.stop_pos;

	always_comb begin
		nxt       = cur;
		acc_nxt   = acc;
		use_base  = cur.active_base;
		try_dig   = 1'b0;
		begin_num = 1'b0;
		prod      = '0;
		if (is_end) begin
			nxt     = aip_pkg::LINE_RESET;
			acc_nxt = '0;
		end else begin
			nxt.char_count = idx_inc;
			unique case (cur.phase)
				aip_pkg::PH_START: begin
					if (signed_mode && ch == aip_pkg::CH_MINUS) begin
						nxt.negate   = 1'b1;
						nxt.stop_pos = idx_inc;
						nxt.phase    = aip_pkg::PH_AFTER_MINUS;
					end else begin
						begin_num = 1'b1;
					end
				end
				aip_pkg::PH_AFTER_MINUS: begin
					begin_num = 1'b1;
				end
				aip_pkg::PH_AFTER_ZERO: begin
					if (ch == aip_pkg::CH_LX || ch == aip_pkg::CH_UX) begin
						nxt.phase = aip_pkg::PH_AFTER_X;
					end else begin
						use_base = (number_base != 6'd0) ? number_base : aip_pkg::BASE_OCT;
						try_dig  = 1'b1;
					end
				end
				aip_pkg::PH_AFTER_X: begin
					// the x is only consumed if a hex digit follows it
					if (dig < 7'(aip_pkg::BASE_HEX)) begin
						use_base = aip_pkg::BASE_HEX;
						try_dig  = 1'b1;
					end else begin
						nxt.phase = aip_pkg::PH_DONE;
					end
				end
				aip_pkg::PH_DIGITS: begin
					try_dig = 1'b1;
				end
				aip_pkg::PH_DONE: begin
				end
				default: begin
				end
			endcase
			if (begin_num) begin
				if (ch == aip_pkg::CH_0) begin
					nxt.stop_pos = idx_inc;
					nxt.phase    = aip_pkg::PH_AFTER_ZERO;
				end else begin
					use_base = (number_base != 6'd0) ? number_base : aip_pkg::BASE_DEC;
					try_dig  = 1'b1;
				end
			end
			if (try_dig) begin
				nxt.active_base = use_base;
				prod = {6'd0, acc} * {{VALUE_WIDTH{1'b0}}, use_base};
				if (dig < {1'b0, use_base}) begin
					acc_nxt      = prod[VALUE_WIDTH-1:0] + VALUE_WIDTH'(dig);
					nxt.stop_pos = idx_inc;
					nxt.phase    = aip_pkg::PH_DIGITS;
				end else begin
					nxt.phase = aip_pkg::PH_DONE;
				end
			end
		end
	end

endmodule

/* rtl/aip_out_reg.sv */
// Result register of the parser: holds one value and stop index until taken.
// No package dependencies.
module aip_out_reg #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  logic [VALUE_WIDTH-1:0] value_d,
	input  logic [7:0]             stop_d,
	input  logic                   out_stall,
	output logic                   out_valid,
	output logic [VALUE_WIDTH-1:0] value,
	output logic [7:0]             stop_index
);

	logic                   valid_s2;
	logic [VALUE_WIDTH-1:0] value_s2;
	logic [7:0]             stop_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			value_s2 <= value_d;
			stop_s2  <= stop_d;
		end
	end

	assign out_valid  = valid_s2;
	assign value      = value_s2;
	assign stop_index = stop_s2;

endmodule

/* rtl/ascii_integer_parser_top.sv */
// Top level of the ASCII integer parser: input register, line state, result register.
// Depends on aip_pkg, aip_step, aip_out_reg and ascii_integer_parser_top_macros.svh.
//
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------
//  in      | in_valid / in_stall   | ch[7:0]
//  out     | out_valid / out_stall | value[VALUE_WIDTH-1:0], stop_index[7:0]
//  cfg     | cfg_we                | cfg_index, cfg_data[5:0]
//
// One character per cycle while in_stall is low; a line end's result passes the input
// register and then the result register, and waits there until it is taken.
// Throughput is set by the single multiply-add of the line state loop.
// Reset clears the line state, the configuration and both valid flags.
// in_stall rises only when a line end sits in the input register and the
// result register is full and stalled; ordinary characters keep flowing.
`include "ascii_integer_parser_top_macros.svh"

module ascii_integer_parser_top #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             ch,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [VALUE_WIDTH-1:0] value,
	output logic [7:0]             stop_index,
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [5:0]             cfg_data
);

	// configuration
	logic [5:0] number_base_q;
	logic       signed_mode_q;

	// input register
	logic       valid_s1;
	logic [7:0] ch_s1;

	// parse state for the current line
	aip_pkg::aip_line_t     line_q;
	logic [VALUE_WIDTH-1:0] acc_q;

	aip_pkg::aip_line_t     line_nxt;
	logic [VALUE_WIDTH-1:0] acc_nxt;
	logic                   is_end;
	logic [VALUE_WIDTH-1:0] res_value;
	logic [7:0]             res_stop;
	logic                   advance;
	logic                   load_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_base_q <= 6'd0;
			signed_mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				aip_pkg::CFG_NUMBER_BASE: number_base_q <= cfg_data;
				aip_pkg::CFG_SIGNED_MODE: signed_mode_q <= cfg_data[0];
			endcase
		end
	end

	// a line end needs a free result slot, anything else moves on at once
	assign advance  = valid_s1 && (!is_end || !out_valid || !out_stall);
	assign load_out = advance && is_end;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			ch_s1 <= ch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= aip_pkg::LINE_RESET;
			acc_q  <= '0;
		end else if (advance) begin
			line_q <= line_nxt;
			acc_q  <= acc_nxt;
		end
	end

	aip_step #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_step (
		.cur        (line_q),
		.acc        (acc_q),
		.ch         (ch_s1),
		.number_base(number_base_q),
		.signed_mode(signed_mode_q),
		.nxt        (line_nxt),
		.acc_nxt    (acc_nxt),
		.is_end     (is_end),
		.res_value  (res_value),
		.res_stop   (res_stop)
	);

	aip_out_reg #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load_out),
		.value_d   (res_value),
		.stop_d    (res_stop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.value     (value),
		.stop_index(stop_index)
	);

	// a held-up input means a line end waiting on a blocked result slot
	`AIP_ASSERT_IMP(a_stall_cause, in_stall, valid_s1 && is_end && out_valid && out_stall)
	// a line end leaves the parse state cleared
	`AIP_ASSERT_NEXT(a_line_clear, load_out, line_q.char_count == 8'd0 && acc_q == '0)
	// the stop position never runs ahead of the characters seen
	`AIP_ASSERT_IMP(a_stop_bound, valid_s1, line_q.stop_pos <= line_q.char_count)

endmodule

/* tb/tb_top.sv */
// Self-checking bench for ascii_integer_parser_top: a directed table of lines, then random lines.
// Depends on aip_pkg and the parser RTL. Results are checked against a local line parser or typed-in values.
module tb_top;

	// one parse result as the output channel carries it
	typedef struct packed {
		logic [31:0] value;
		logic [7:0]  stop_index;
	} parse_t;

	// one row of the directed table: settings, line body, terminator and,
	// where it is obvious, the result typed in by hand
	typedef struct {
		logic [5:0]  radix;
		bit          sgn;
		string       text;
		logic [7:0]  term;
		bit          typed;
		logic [31:0] want_value;
		logic [7:0]  want_stop;
	} line_row_t;

	localparam int NUM_ROWS   = 14;
	localparam int NUM_PHASES = 9;
	localparam int PHASE_CHARS = 60;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  ch = 8'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] value;
	logic [7:0]  stop_index;
	logic        cfg_we = 1'b0;
	logic        cfg_index = aip_pkg::CFG_NUMBER_BASE;
	logic [5:0]  cfg_data = 6'd0;

	parse_t      expected_parses[$];
	logic [7:0]  line_buf[$];
	int unsigned mismatches = 0;
	int unsigned lines_sent = 0;
	int unsigned chars_sent = 0;
	int unsigned parses_checked = 0;
	bit          calm = 1'b0;   // no idling on either side while set

	// local copy of the parser: registers and per-line state
	logic [5:0]          lp_cfg_base = 6'd0;
	logic                lp_cfg_signed = 1'b0;
	aip_pkg::aip_phase_t lp_phase = aip_pkg::PH_START;
	logic [5:0]          lp_base = 6'd0;
	logic [31:0]         lp_acc = 32'd0;
	logic                lp_neg = 1'b0;
	logic [7:0]          lp_count = 8'd0;
	logic [7:0]          lp_stop = 8'd0;

	line_row_t rows [NUM_ROWS] = '{
		// after reset: base detect, unsigned
		'{6'd0,  1'b0, "",     aip_pkg::CH_LF,  1'b1, 32'd0,          8'd0},
		'{6'd0,  1'b0, "0x1f", aip_pkg::CH_CR,  1'b1, 32'd31,         8'd4},
		// 0x with nothing or no hex digit behind: x stays unconsumed
		'{6'd0,  1'b0, "0x",   aip_pkg::CH_LF,  1'b1, 32'd0,          8'd1},
		'{6'd0,  1'b0, "0xg",  aip_pkg::CH_NUL, 1'b1, 32'd0,          8'd1},
		// leading zero gives octal; 9 is no octal digit
		'{6'd0,  1'b0, "017",  aip_pkg::CH_LF,  1'b1, 32'd15,         8'd3},
		'{6'd0,  1'b0, "09",   aip_pkg::CH_LF,  1'b1, 32'd0,          8'd1},
		// minus is an ordinary stop character when unsigned
		'{6'd0,  1'b0, "-5",   aip_pkg::CH_LF,  1'b1, 32'd0,          8'd0},
		'{6'd0,  1'b0, "12a",  aip_pkg::CH_CR,  1'b1, 32'd12,         8'd2},
		// lone minus, then a negated value
		'{6'd0,  1'b1, "-",    aip_pkg::CH_LF,  1'b1, 32'd0,          8'd1},
		'{6'd0,  1'b1, "-7",   aip_pkg::CH_LF,  1'b1, 32'hFFFF_FFF9,  8'd2},
		// base 1 takes only zeros
		'{6'd1,  1'b1, "01",   aip_pkg::CH_LF,  1'b1, 32'd0,          8'd1},
		// hex prefix wins over a nonzero base
		'{6'd36, 1'b0, "0XF",  aip_pkg::CH_LF,  1'b1, 32'd15,         8'd3},
		'{6'd36, 1'b0, "\377", aip_pkg::CH_LF,  1'b1, 32'd0,          8'd0},
		// wraps the accumulator; left to the local parser
		'{6'd36, 1'b0, "fffffffff", aip_pkg::CH_CR, 1'b0, 32'd0,      8'd0}
	};

	ascii_integer_parser_top #(
		.VALUE_WIDTH(32)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.ch        (ch),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value),
		.stop_index(stop_index),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// Local line parser
	// ---------------------------------------------------------------

	// digit value 0..15, or NOT_DIGIT; folding case maps A-F onto a-f
	function automatic logic [6:0] hex_digit(input logic [7:0] c);
		logic [7:0] folded;
		folded = c | 8'h20;
		if (c >= aip_pkg::CH_0 && c <= aip_pkg::CH_9) begin
			return 7'(c - aip_pkg::CH_0);
		end
		if (folded >= aip_pkg::CH_LA && folded <= aip_pkg::CH_LF_HEX) begin
			return 7'(folded - aip_pkg::CH_LA + 8'd10);
		end
		return aip_pkg::NOT_DIGIT;
	endfunction

	// position counters stick at 255
	function automatic logic [7:0] bump(input logic [7:0] x);
		return x + {7'd0, ~&x};
	endfunction

	task automatic clear_line();
		lp_phase = aip_pkg::PH_START;
		lp_base  = 6'd0;
		lp_acc   = 32'd0;
		lp_neg   = 1'b0;
		lp_count = 8'd0;
		lp_stop  = 8'd0;
	endtask

	// multiply-add if the digit fits the active base, else the parse is over
	task automatic take_digit(input logic [7:0] c, input logic [7:0] pos);
		logic [6:0] v;
		v = hex_digit(c);
		if (v < {1'b0, lp_base}) begin
			lp_acc   = lp_acc * 32'(lp_base) + 32'(v);
			lp_stop  = bump(pos);
			lp_phase = aip_pkg::PH_DIGITS;
		end else begin
			lp_phase = aip_pkg::PH_DONE;
		end
	endtask

	// first character of the number proper; a zero defers the base decision
	task automatic open_number(input logic [7:0] c, input logic [7:0] pos);
		if (c == aip_pkg::CH_0) begin
			lp_stop  = bump(pos);
			lp_phase = aip_pkg::PH_AFTER_ZERO;
		end else begin
			lp_base = (lp_cfg_base != 6'd0) ? lp_cfg_base : aip_pkg::BASE_DEC;
			take_digit(c, pos);
		end
	endtask

	// advance the local parser by one character; got is set on a line end
	task automatic parse_char(input logic [7:0] c, output bit got, output parse_t res);
		logic [7:0] pos;
		got = 1'b0;
		res = '0;
		if (c == aip_pkg::CH_CR || c == aip_pkg::CH_LF || c == aip_pkg::CH_NUL) begin
			got = 1'b1;
			res.value = lp_neg ? (32'd0 - lp_acc) : lp_acc;
			res.stop_index = lp_stop;
			clear_line();
		end else begin
			pos = lp_count;
			lp_count = bump(lp_count);
			case (lp_phase)
				aip_pkg::PH_START: begin
					if (lp_cfg_signed && c == aip_pkg::CH_MINUS) begin
						lp_neg   = 1'b1;
						lp_stop  = bump(pos);
						lp_phase = aip_pkg::PH_AFTER_MINUS;
					end else begin
						open_number(c, pos);
					end
				end
				aip_pkg::PH_AFTER_MINUS: begin
					open_number(c, pos);
				end
				aip_pkg::PH_AFTER_ZERO: begin
					// x is held until we know a hex digit follows
					if (c == aip_pkg::CH_LX || c == aip_pkg::CH_UX) begin
						lp_phase = aip_pkg::PH_AFTER_X;
					end else begin
						lp_base = (lp_cfg_base != 6'd0) ? lp_cfg_base : aip_pkg::BASE_OCT;
						take_digit(c, pos);
					end
				end
				aip_pkg::PH_AFTER_X: begin
					if (hex_digit(c) < 7'd16) begin
						lp_base = aip_pkg::BASE_HEX;
						take_digit(c, pos);
					end else begin
						lp_phase = aip_pkg::PH_DONE;
					end
				end
				aip_pkg::PH_DIGITS: begin
					take_digit(c, pos);
				end
				default: begin
				end
			endcase
		end
	endtask

	// ---------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------

	task automatic log_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// offer one character as a request and hold it until taken; the
	// local parser runs in the step of the accepting edge
	task automatic send_char(input logic [7:0] c, output bit got, output parse_t res);
		while (!calm && $urandom_range(99) < 21) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		ch <= c;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		chars_sent++;
		parse_char(c, got, res);
	endtask

	task automatic send_buffer();
		bit     got;
		parse_t res;
		foreach (line_buf[i]) begin
			send_char(line_buf[i], got, res);
			if (got) begin
				expected_parses.push_back(res);
			end
		end
		lines_sent++;
	endtask

	// register writes only with the parser idle: no request in flight, every
	// result back, and a few cycles for a line that produced nothing
	task automatic write_reg(input logic idx, input logic [5:0] data);
		in_valid <= 1'b0;
		while (expected_parses.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == aip_pkg::CFG_NUMBER_BASE) begin
			lp_cfg_base = data;
		end else begin
			lp_cfg_signed = data[0];
		end
	endtask

	// a digit that mostly fits the radix; now and then any hex digit
	function automatic logic [7:0] digit_for(input int unsigned radix);
		int unsigned span;
		int unsigned v;
		span = (radix == 0) ? 10 : ((radix > 16) ? 16 : radix);
		if ($urandom_range(9) == 0) begin
			v = $urandom_range(15);
		end else begin
			v = $urandom_range(span - 1);
		end
		if (v < 10) begin
			return aip_pkg::CH_0 + 8'(v);
		end
		return ($urandom_range(1) ? aip_pkg::CH_UA : aip_pkg::CH_LA) + 8'(v - 10);
	endfunction

	// any byte that does not end the line
	function automatic logic [7:0] noise_byte();
		logic [7:0] b;
		b = 8'($urandom_range(1, 255));
		if (b == aip_pkg::CH_LF || b == aip_pkg::CH_CR) begin
			b = 8'hFF;
		end
		return b;
	endfunction

	// mostly well-formed numbers with random content, some noise lines
	task automatic build_line();
		int unsigned kind;
		int unsigned pre;
		int unsigned radix;
		int unsigned n;
		int unsigned term;
		line_buf.delete();
		kind = $urandom_range(99);
		radix = lp_cfg_base;
		if (kind < 12) begin
			n = $urandom_range(8);
			repeat (n) line_buf.push_back(noise_byte());
		end else begin
			if ($urandom_range(1)) begin
				line_buf.push_back(aip_pkg::CH_MINUS);
			end
			pre = $urandom_range(9);
			if (pre <= 2) begin
				line_buf.push_back(aip_pkg::CH_0);
				line_buf.push_back($urandom_range(1) ? aip_pkg::CH_LX : aip_pkg::CH_UX);
				radix = 16;
			end else if (pre <= 4) begin
				line_buf.push_back(aip_pkg::CH_0);
				if (radix == 0) begin
					radix = 8;
				end
			end else if (pre == 5) begin
				// prefix with no hex digit after it
				line_buf.push_back(aip_pkg::CH_0);
				line_buf.push_back($urandom_range(1) ? aip_pkg::CH_LX : aip_pkg::CH_UX);
				if ($urandom_range(1)) begin
					line_buf.push_back(8'h20 + 8'($urandom_range(15)));
				end
			end
			if (pre != 5) begin
				n = $urandom_range(12);
				repeat (n) line_buf.push_back(digit_for(radix));
			end
			if ($urandom_range(9) < 3) begin
				n = $urandom_range(1, 3);
				repeat (n) line_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
			end
		end
		term = $urandom_range(2);
		line_buf.push_back((term == 0) ? aip_pkg::CH_CR :
			((term == 1) ? aip_pkg::CH_LF : aip_pkg::CH_NUL));
	endtask

	// result side stalls about a fifth of the time, never while calm
	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 21);
	end

	// ---------------------------------------------------------------
	// Result checker
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		parse_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_parses.size() == 0) begin
				log_mismatch($sformatf("result %h/%0d with none expected", value, stop_index));
			end else begin
				want = expected_parses.pop_front();
				parses_checked++;
				if (value !== want.value) begin
					log_mismatch($sformatf("value %h, expected %h", value, want.value));
				end
				if (stop_index !== want.stop_index) begin
					log_mismatch($sformatf("stop_index %0d, expected %0d",
						stop_index, want.stop_index));
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	initial begin
		bit          got;
		parse_t      res;
		parse_t      typed_res;
		logic [5:0]  phase_base [NUM_PHASES];
		bit          phase_sgn [NUM_PHASES];
		int unsigned sent;
		int unsigned drain;

		phase_base = '{6'd0, 6'd10, 6'd16, 6'd36, 6'd1, 6'd8, 6'd2, 6'd0, 6'd0};
		phase_sgn  = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
		phase_base[NUM_PHASES - 1] = 6'($urandom_range(36));
		phase_sgn[NUM_PHASES - 1]  = 1'($urandom_range(1));

		clear_line();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed table; registers change only where a row asks for it
		foreach (rows[r]) begin
			if (rows[r].radix != lp_cfg_base) begin
				write_reg(aip_pkg::CFG_NUMBER_BASE, rows[r].radix);
			end
			if (rows[r].sgn != lp_cfg_signed) begin
				write_reg(aip_pkg::CFG_SIGNED_MODE, {5'd0, rows[r].sgn});
			end
			for (int i = 0; i < rows[r].text.len(); i++) begin
				send_char(rows[r].text[i], got, res);
			end
			send_char(rows[r].term, got, res);
			typed_res.value = rows[r].want_value;
			typed_res.stop_index = rows[r].want_stop;
			expected_parses.push_back(rows[r].typed ? typed_res : res);
			lines_sent++;
		end

		// random phases, one register setting each; every write waits for
		// the parser to drain, so the sender pauses until all results are in
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			write_reg(aip_pkg::CFG_NUMBER_BASE, phase_base[ph]);
			write_reg(aip_pkg::CFG_SIGNED_MODE, {5'd0, phase_sgn[ph]});
			calm = (ph == 4);
			sent = 0;
			if (ph == 1) begin
				// past the 255 mark: both position counters saturate
				line_buf.delete();
				repeat (280) line_buf.push_back(aip_pkg::CH_0 + 8'($urandom_range(9)));
				line_buf.push_back(aip_pkg::CH_LF);
				send_buffer();
			end
			while (sent < PHASE_CHARS) begin
				build_line();
				sent += line_buf.size();
				send_buffer();
			end
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		drain = 0;
		while (expected_parses.size() != 0 && drain < 5000) begin
			@(posedge clk);
			drain++;
		end
		repeat (10) @(posedge clk);
		if (expected_parses.size() != 0) begin
			log_mismatch($sformatf("%0d results never arrived", expected_parses.size()));
		end

		$display("covered %0d lines (%0d characters), %0d results checked", lines_sent,
			chars_sent, parses_checked);
		$display("bases 0, 1, 2, 8, 10, 16, 36 and a random one, signed and unsigned");
		if (mismatches == 0) begin
			$display("ascii_integer_parser_top test passed");
		end else begin
			$display("ascii_integer_parser_top test failed");
		end
		$finish;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#2000000;
		$display("ascii_integer_parser_top test failed");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl
rtl/aip_pkg.sv
rtl/aip_step.sv
rtl/aip_out_reg.sv
rtl/ascii_integer_parser_top.sv
tb/tb_top.sv
